// ----- rtl/rmof_pkg.sv -----
`default_nettype none
package rmof_pkg;

  localparam int unsigned MaxSamplesDef = 128;
  localparam int unsigned StampW = 64;
  localparam int unsigned CpuW = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned MultW = 8;
  localparam logic [MultW-1:0] MultReset = 8'd8;

  typedef enum logic {
    KIND_DELTA = 1'b0,
    KIND_MIGR  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              last;
    logic [StampW-1:0] delta;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND_RD,
    ST_CAND_WT,
    ST_SCAN,
    ST_CHECK,
    ST_LIMIT,
    ST_LIMIT_CHK,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/rmof_front.sv -----
`default_nettype none
module rmof_front import rmof_pkg::*; (
  input  wire logic [StampW-1:0] open_stamp_i,
  input  wire logic [StampW-1:0] close_stamp_i,
  input  wire logic [CpuW-1:0]   cpu_open_i,
  input  wire logic [CpuW-1:0]   cpu_close_i,
  input  wire logic              last_i,
  output entry_t                 entry_o
);

  logic bad;

  // cpu change or stamps that do not increase count as a migration
  assign bad = (cpu_open_i != cpu_close_i) || (close_stamp_i <= open_stamp_i);

  always_comb begin
    entry_o.kind  = bad ? KIND_MIGR : KIND_DELTA;
    entry_o.last  = last_i;
    entry_o.delta = close_stamp_i - open_stamp_i;
  end

endmodule
`default_nettype wire

// ----- rtl/rmof_queue.sv -----
`default_nettype none
module rmof_queue import rmof_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      pop_data_o
);

  entry_t     slots_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slots_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rmof_back.sv -----
`default_nettype none
module rmof_back import rmof_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [MultW-1:0]  mult_i,
  input  wire logic              q_valid_i,
  input  wire entry_t            q_data_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [StampW-1:0]      robust_o,
  output logic [CountW-1:0]      kept_o,
  output logic [CountW-1:0]      migr_o,
  output logic [CountW-1:0]      outl_o,
  output logic                   ovf_o
);

  localparam int unsigned IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] Max = CW'(MAX_SAMPLES);

  logic [StampW-1:0] mem [MAX_SAMPLES];
  logic [StampW-1:0] rd_data_q;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d, kept_q, kept_d, tgt_q, tgt_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d, pj_q, pj_d, acc_q, acc_d;
  logic              p_q, p_d, cnt_mode_q, cnt_mode_d, final_q, final_d;
  logic [CountW-1:0] mig_q, mig_d;
  logic              ovf_q, ovf_d;
  logic [StampW-1:0] cand_q, cand_d, med_q, med_d, lim_q, lim_d, res_q, res_d;
  logic [StampW+MultW-1:0] prod;
  logic [MultW-1:0]  mult_eff;
  logic [CW-1:0]     n_new;
  logic              hit;
  logic [CW-1:0]     outl;

  logic              ov_q, ov_d;
  logic [StampW-1:0] o_res_q, o_res_d;
  logic [CountW-1:0] o_kept_q, o_kept_d, o_mig_q, o_mig_d, o_outl_q, o_outl_d;
  logic              o_ovf_q, o_ovf_d;

  assign mult_eff = (mult_i == '0) ? MultW'(1) : mult_i;
  assign prod     = med_q * mult_eff;
  assign outl     = cnt_q - kept_q;

  function automatic logic [CountW-1:0] sat8(input logic [CW-1:0] v);
    return (32'(v) > 32'd255) ? 8'hFF : CountW'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IW-1:0]] <= q_data_i.delta;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; kept_d = kept_q; tgt_d = tgt_q;
    i_d = i_q; j_d = j_q; pj_d = pj_q; acc_d = acc_q; p_d = 1'b0;
    cnt_mode_d = cnt_mode_q; final_d = final_q; mig_d = mig_q; ovf_d = ovf_q;
    cand_d = cand_q; med_d = med_q; lim_d = lim_q; res_d = res_q;
    ov_d = ov_q; o_res_d = o_res_q; o_kept_d = o_kept_q; o_mig_d = o_mig_q;
    o_outl_d = o_outl_q; o_ovf_d = o_ovf_q;
    q_pop_o = 1'b0; wr_en = 1'b0; rd_addr = i_q[IW-1:0];
    n_new = cnt_q; hit = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && (!q_data_i.last || !ov_q)) begin
          q_pop_o = 1'b1;
          if (q_data_i.kind == KIND_MIGR) begin
            if (mig_q != 8'hFF) mig_d = mig_q + 8'd1;
          end else if (cnt_q < Max) begin
            wr_en = 1'b1;
            n_new = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          cnt_d = n_new;
          if (q_data_i.last) begin
            i_d = '0; tgt_d = n_new >> 1; final_d = 1'b0; cnt_mode_d = 1'b0;
            kept_d = '0; res_d = '0;
            state_d = (n_new == '0) ? ST_DONE : ST_CAND_RD;
          end
        end
      end
      ST_CAND_RD: state_d = ST_CAND_WT;
      ST_CAND_WT: begin
        cand_d = rd_data_q; j_d = '0; acc_d = '0; state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_addr = j_q[IW-1:0];
        if (j_q < cnt_q) begin
          p_d = 1'b1; pj_d = j_q; j_d = j_q + CW'(1);
        end
        if (p_q) begin
          if (cnt_mode_q) hit = (rd_data_q <= lim_q);
          else hit = (rd_data_q < cand_q) || ((rd_data_q == cand_q) && (pj_q < i_q));
          if (hit) acc_d = acc_q + CW'(1);
          if (pj_q == cnt_q - CW'(1)) begin
            if (cnt_mode_q) begin
              kept_d = acc_d; state_d = ST_LIMIT_CHK;
            end else begin
              state_d = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (acc_q == tgt_q) begin
          if (final_q) begin
            res_d = cand_q; state_d = ST_DONE;
          end else begin
            med_d = cand_q; state_d = ST_LIMIT;
          end
        end else begin
          i_d = i_q + CW'(1); state_d = ST_CAND_RD;
        end
      end
      ST_LIMIT: begin
        lim_d  = prod[StampW-1:0];
        if ((med_q == '0) || (prod[StampW+MultW-1:StampW] != '0)) begin
          kept_d = cnt_q; cnt_mode_d = 1'b1; state_d = ST_LIMIT_CHK;
        end else begin
          cnt_mode_d = 1'b1; j_d = '0; acc_d = '0; state_d = ST_SCAN;
        end
      end
      ST_LIMIT_CHK: begin
        // retained deltas form the sorted prefix, so rank select still works
        cnt_mode_d = 1'b0;
        if (kept_q == '0) begin
          res_d = '0; state_d = ST_DONE;
        end else begin
          final_d = 1'b1; tgt_d = kept_q >> 1; i_d = '0; state_d = ST_CAND_RD;
        end
      end
      ST_DONE: begin
        ov_d = 1'b1; o_res_d = res_q; o_kept_d = sat8(kept_q); o_mig_d = mig_q;
        o_outl_d = sat8(outl); o_ovf_d = ovf_q;
        cnt_d = '0; mig_d = '0; ovf_d = 1'b0; kept_d = '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d; i_q <= i_d; j_q <= j_d; pj_q <= pj_d; acc_q <= acc_d;
    cand_q <= cand_d; med_q <= med_d; lim_q <= lim_d; res_q <= res_d;
    final_q <= final_d;
    o_res_q <= o_res_d; o_kept_q <= o_kept_d; o_mig_q <= o_mig_d;
    o_outl_q <= o_outl_d; o_ovf_q <= o_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; kept_q <= '0; mig_q <= '0; ovf_q <= 1'b0;
      p_q <= 1'b0; cnt_mode_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; kept_q <= kept_d; mig_q <= mig_d;
      ovf_q <= ovf_d; p_q <= p_d; cnt_mode_q <= cnt_mode_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign robust_o    = o_res_q;
  assign kept_o      = o_kept_q;
  assign migr_o      = o_mig_q;
  assign outl_o      = o_outl_q;
  assign ovf_o       = o_ovf_q;

endmodule
`default_nettype wire

// ----- rtl/robust_median_outlier_filter_unit.sv -----
`default_nettype none
// Timing-sample filter. Each input transaction carries one sample; samples
// with a cpu change or non-increasing stamps are counted as migrations, the
// rest have their delta stored (up to MAX_SAMPLES, beyond that the overflow
// flag is set). While the back end is idle, samples load at one per cycle
// through a two-entry queue. The sample with tlast ends the run: the store
// is walked by rank selection on one memory read port, each candidate
// taking a read and a sweep over the stored deltas; the median pick, the
// outlier count sweep and the final pick all run after the tlast sample
// leaves the queue. Meanwhile the queue fills and then holds off the input.
// One result is held until taken; a further tlast sample waits for that.
module robust_median_outlier_filter_unit import rmof_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [7:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // open_stamp, close_stamp, cpu_open, cpu_close
  input  wire logic [191:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // robust_cycles, kept_count, migration_rejects, outlier_rejects
  output logic [87:0]       m_axis_tdata,
  // capacity_overflow
  output logic [0:0]        m_axis_tuser
);

  logic [MultW-1:0] mult_q;
  entry_t           in_entry, q_entry;
  logic             q_full, q_valid, q_pop, push;
  logic [StampW-1:0] robust;
  logic [CountW-1:0] kept, migr, outl;
  logic              ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MultReset;
    end else if (cfg_we_i) begin
      mult_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  rmof_front u_front (
    .open_stamp_i  (s_axis_tdata[63:0]),
    .close_stamp_i (s_axis_tdata[127:64]),
    .cpu_open_i    (s_axis_tdata[159:128]),
    .cpu_close_i   (s_axis_tdata[191:160]),
    .last_i        (s_axis_tlast),
    .entry_o       (in_entry)
  );

  rmof_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (in_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_entry)
  );

  rmof_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mult_i      (mult_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .robust_o    (robust),
    .kept_o      (kept),
    .migr_o      (migr),
    .outl_o      (outl),
    .ovf_o       (ovf)
  );

  assign m_axis_tdata = {outl, migr, kept, robust};
  assign m_axis_tuser = ovf;

endmodule
`default_nettype wire
